/* rtl/osw_pkg.sv */
// Shared constants, types and state codes of the ordered-sum ways counter.
`default_nettype none

package osw_pkg;

  // Default depth of the part store and default largest target of the ways table.
  localparam int unsigned MaxPartsDef  = 64;
  localparam int unsigned MaxTargetDef = 1024;

  // Fixed field widths.
  localparam int unsigned PartW   = 16;
  localparam int unsigned TargetW = 11;
  localparam int unsigned WaysW   = 32;
  // Wide enough for any part value and any table index, plus one bit.
  localparam int unsigned WideW   = 17;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } osw_state_e;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic             valid;
    logic [WaysW-1:0] ways;
    logic             ovf;
  } res_t;

endpackage

`default_nettype wire

/* rtl/osw_ram.sv */
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module osw_ram import osw_pkg::*; #(
  parameter int unsigned DEPTH = MaxPartsDef,
  parameter int unsigned DW    = PartW,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/osw_ctrl.sv */
// Sequencer: loads parts, then fills the ways table entry by entry through the two RAMs.
`default_nettype none

module osw_ctrl import osw_pkg::*; #(
  parameter int unsigned MAX_PARTS  = MaxPartsDef,
  parameter int unsigned MAX_TARGET = MaxTargetDef,
  parameter int unsigned PIdxW      = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1,
  parameter int unsigned CountW     = $clog2(MAX_PARTS + 1),
  parameter int unsigned TabAW      = $clog2(MAX_TARGET + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input requests.
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [PartW-1:0] part_value_i,
  input  wire logic             last_part_i,
  // Saturated target and output register status.
  input  wire logic [TabAW-1:0] goal_i,
  input  wire logic             out_free_i,
  // Part store port.
  output logic                  part_we_o,
  output logic      [PIdxW-1:0] part_waddr_o,
  output logic      [PartW-1:0] part_wdata_o,
  output logic      [PIdxW-1:0] part_raddr_o,
  input  wire logic [PartW-1:0] part_rdata_i,
  // Ways table port.
  output logic                  tab_we_o,
  output logic      [TabAW-1:0] tab_waddr_o,
  output logic      [WaysW-1:0] tab_wdata_o,
  output logic      [TabAW-1:0] tab_raddr_o,
  input  wire logic [WaysW-1:0] tab_rdata_i,
  // Finished result.
  output res_t                  res_o
);

  osw_state_e        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [TabAW-1:0]  goal_q, goal_d;
  logic [TabAW-1:0]  idx_q, idx_d;
  logic [CountW-1:0] j_q, j_d;
  logic [WaysW-1:0]  acc_q, acc_d;
  logic              s1_vld_q, s1_vld_d;
  logic              s2_vld_q, s2_vld_d;

  logic              accept;
  logic              store_full;
  logic [WideW-1:0]  part_wide;
  logic [WideW-1:0]  idx_wide;
  logic [WideW-1:0]  diff_wide;
  logic              hit;

  // Requests are taken only while loading, which is exactly when stall is low.
  assign accept     = in_valid_i && (state_q == ST_LOAD);
  assign store_full = (count_q >= CountW'(MAX_PARTS));

  // First pipeline stage: the stored part is back, form the table address i - v.
  assign part_wide   = WideW'(part_rdata_i);
  assign idx_wide    = WideW'(idx_q);
  assign diff_wide   = idx_wide - part_wide;
  assign hit         = (part_wide != '0) && (part_wide <= idx_wide);
  assign tab_raddr_o = TabAW'(diff_wide);

  // Next state, memory requests and result.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    goal_d       = goal_q;
    idx_d        = idx_q;
    j_d          = j_q;
    acc_d        = acc_q + (s2_vld_q ? tab_rdata_i : '0);
    s1_vld_d     = 1'b0;
    s2_vld_d     = s1_vld_q && hit;
    in_stall_o   = 1'b1;
    part_we_o    = 1'b0;
    part_waddr_o = PIdxW'(count_q);
    part_wdata_o = part_value_i;
    part_raddr_o = PIdxW'(j_q);
    tab_we_o     = 1'b0;
    tab_waddr_o  = idx_q;
    tab_wdata_o  = acc_q;
    res_o.valid  = 1'b0;
    res_o.ways   = acc_q;
    res_o.ovf    = ovf_q;

    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (accept) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            part_we_o = 1'b1;
            count_d   = count_q + CountW'(1);
          end
          if (last_part_i) begin
            // Entry zero counts the empty sequence.
            tab_we_o    = 1'b1;
            tab_waddr_o = '0;
            tab_wdata_o = WaysW'(1);
            goal_d      = goal_i;
            idx_d       = TabAW'(1);
            j_d         = '0;
            if (goal_i == '0) begin
              acc_d   = WaysW'(1);
              state_d = ST_EMIT;
            end else begin
              acc_d   = '0;
              state_d = ST_RUN;
            end
          end
        end
      end

      ST_RUN: begin
        // Issue one part read per cycle.
        s1_vld_d = 1'b1;
        j_d      = j_q + CountW'(1);
        if ((j_q + CountW'(1)) >= count_q) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        // Once the pipeline is empty, the sum of entry i is complete.
        if (!s1_vld_q && !s2_vld_q) begin
          tab_we_o = 1'b1;
          if (idx_q == goal_q) begin
            state_d = ST_EMIT;
          end else begin
            idx_d   = idx_q + TabAW'(1);
            j_d     = '0;
            acc_d   = '0;
            state_d = ST_RUN;
          end
        end
      end

      ST_EMIT: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    goal_q <= goal_d;
    idx_q  <= idx_d;
    j_q    <= j_d;
    acc_q  <= acc_d;
  end

endmodule

`default_nettype wire

/* rtl/ordered_sum_ways_counter.sv */
// Parts load at one per cycle while in_stall_o is low; the last part starts the table fill.
// The fill time is set by the single read port of the part store, which reads
// one stored part per cycle for each table entry up to the saturated target.
// One list is worked on at a time; the result register lets the next list load.
// Reset clears control state and the target register; both RAMs keep their contents, no clearing pass.
`default_nettype none

module ordered_sum_ways_counter import osw_pkg::*; #(
  parameter int unsigned MAX_PARTS  = MaxPartsDef,
  parameter int unsigned MAX_TARGET = MaxTargetDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TargetW-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PartW-1:0]   part_value_i,
  input  wire logic               last_part_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [WaysW-1:0]   ways_count_o,
  output logic                    list_overflow_o
);

  localparam int unsigned PIdxW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CountW = $clog2(MAX_PARTS + 1);
  localparam int unsigned TabAW  = $clog2(MAX_TARGET + 1);

  logic [TargetW-1:0] target_q;
  logic [TabAW-1:0]   goal;
  logic               out_valid_q;
  logic [WaysW-1:0]   ways_q;
  logic               ovf_q;
  logic               out_free;
  res_t               res;

  logic               part_we;
  logic [PIdxW-1:0]   part_waddr;
  logic [PartW-1:0]   part_wdata;
  logic [PIdxW-1:0]   part_raddr;
  logic [PartW-1:0]   part_rdata;
  logic               tab_we;
  logic [TabAW-1:0]   tab_waddr;
  logic [WaysW-1:0]   tab_wdata;
  logic [TabAW-1:0]   tab_raddr;
  logic [WaysW-1:0]   tab_rdata;

  // Target register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Saturate the target to the table size.
  assign goal = (WideW'(target_q) > WideW'(MAX_TARGET)) ? TabAW'(MAX_TARGET)
                                                        : TabAW'(target_q);

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      ways_q <= res.ways;
      ovf_q  <= res.ovf;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ways_count_o    = ways_q;
  assign list_overflow_o = ovf_q;

  osw_ctrl #(
    .MAX_PARTS  (MAX_PARTS),
    .MAX_TARGET (MAX_TARGET),
    .PIdxW      (PIdxW),
    .CountW     (CountW),
    .TabAW      (TabAW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .part_value_i (part_value_i),
    .last_part_i  (last_part_i),
    .goal_i       (goal),
    .out_free_i   (out_free),
    .part_we_o    (part_we),
    .part_waddr_o (part_waddr),
    .part_wdata_o (part_wdata),
    .part_raddr_o (part_raddr),
    .part_rdata_i (part_rdata),
    .tab_we_o     (tab_we),
    .tab_waddr_o  (tab_waddr),
    .tab_wdata_o  (tab_wdata),
    .tab_raddr_o  (tab_raddr),
    .tab_rdata_i  (tab_rdata),
    .res_o        (res)
  );

  // Part store.
  osw_ram #(
    .DEPTH (MAX_PARTS),
    .DW    (PartW),
    .AW    (PIdxW)
  ) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (part_we),
    .waddr_i (part_waddr),
    .wdata_i (part_wdata),
    .raddr_i (part_raddr),
    .rdata_o (part_rdata)
  );

  // Ways table.
  osw_ram #(
    .DEPTH (MAX_TARGET + 1),
    .DW    (WaysW),
    .AW    (TabAW)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result produced while output register is blocked");

  // The block stops taking parts right after the last part of a list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_part_i) |=> in_stall_o)
    else $error("part accepted while the table is being filled");

  // Table entries are written only up to the saturated target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tab_we && in_stall_o) |-> (tab_waddr <= goal))
    else $error("table write beyond the target");

endmodule

`default_nettype wire

/* dv/ordered_sum_ways_counter_test.sv */
// Self-checking testbench for the ordered-sum ways counter.
`timescale 1ns / 100ps

module ordered_sum_ways_counter_test;
  import osw_pkg::*;

  // One expected result: the wrapped count and the overflow flag of its list.
  typedef struct packed {
    logic [WaysW-1:0] ways;
    logic             ovf;
  } ways_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [TargetW-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [PartW-1:0]   part_value_i = '0;
  logic               last_part_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WaysW-1:0]   ways_count_o;
  logic               list_overflow_o;

  // Mirror of the block state used to predict each count.
  logic [PartW-1:0]   held_parts [MaxPartsDef];
  int unsigned        held_count = 0;
  logic               held_ovf = 1'b0;
  logic [TargetW-1:0] target_reg = '0;
  ways_result_t       pending_counts [$];
  ways_result_t       oldest_count;

  int unsigned        fail_count = 0;
  int unsigned        parts_sent = 0;
  bit                 in_gaps_on = 1'b1;
  bit                 out_gaps_on = 1'b1;
  int unsigned        stall_left = 0;
  int unsigned        long_hold_left = 0;

  ordered_sum_ways_counter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .part_value_i    (part_value_i),
    .last_part_i     (last_part_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ways_count_o    (ways_count_o),
    .list_overflow_o (list_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Count the ordered sequences of held parts that sum to the goal, mod 2^32.
  function automatic logic [WaysW-1:0] count_orders(input int unsigned goal);
    logic [WaysW-1:0] tbl [0:MaxTargetDef];
    logic [WaysW-1:0] acc;
    tbl[0] = 1;
    for (int unsigned i = 1; i <= goal; i++) begin
      acc = '0;
      for (int unsigned j = 0; j < held_count; j++) begin
        if (held_parts[j] != 0 && held_parts[j] <= i) begin
          acc += tbl[i - held_parts[j]];
        end
      end
      tbl[i] = acc;
    end
    return tbl[goal];
  endfunction

  // Update the mirror for one accepted request; the last part yields a count.
  task automatic note_part(input logic [PartW-1:0] value, input logic last);
    int unsigned goal;
    if (held_count < MaxPartsDef) begin
      held_parts[held_count] = value;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      goal = (target_reg > MaxTargetDef) ? MaxTargetDef : target_reg;
      pending_counts.push_back('{ways: count_orders(goal), ovf: held_ovf});
      held_count = 0;
      held_ovf = 1'b0;
    end
  endtask

  // Offer one part after a random gap and wait until the block takes it.
  task automatic send_part(input logic [PartW-1:0] value, input logic last);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    part_value_i <= value;
    last_part_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    note_part(value, last);
    parts_sent++;
  endtask

  // Pick a part value: mostly useful small values, sometimes any 16-bit value or zero.
  function automatic logic [PartW-1:0] pick_part(input int unsigned vmax);
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return '0;
    if (r < 4) return PartW'($urandom_range(0, 16'hFFFF));
    return PartW'($urandom_range(1, (vmax < 1) ? 1 : vmax));
  endfunction

  task automatic send_list(input int unsigned len, input int unsigned vmax);
    for (int unsigned k = 0; k < len; k++) begin
      send_part(pick_part(vmax), k == len - 1);
    end
  endtask

  // Drop valid and wait for every expected count, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [TargetW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    target_reg = value;
  endtask

  // Zero target, small counts, zero and oversized parts, saturated target.
  task automatic test_directed_cases();
    write_target(11'd0);
    send_part(16'd5, 1'b1);
    wait_idle();
    write_target(11'd4);
    send_part(16'd1, 1'b0);
    send_part(16'd2, 1'b0);
    send_part(16'd3, 1'b1);
    send_part(16'd0, 1'b0);
    send_part(16'd1, 1'b1);
    send_part(16'hFFFF, 1'b0);
    send_part(16'hAAAA, 1'b0);
    send_part(16'h5555, 1'b0);
    send_part(16'd1, 1'b1);
    send_part(16'd2, 1'b0);
    send_part(16'd2, 1'b0);
    send_part(16'd1, 1'b1);
    wait_idle();
    write_target(11'd1024);
    send_part(16'd1, 1'b0);
    send_part(16'd2, 1'b0);
    send_part(16'd3, 1'b1);
    wait_idle();
    write_target(11'h7FF);
    send_part(16'd1, 1'b1);
    send_part(16'd1, 1'b0);
    send_part(16'd2, 1'b1);
    wait_idle();
  endtask

  // Full list, one part too many (the last one dropped), and well past full.
  task automatic test_list_overflow();
    write_target(11'd10);
    send_list(MaxPartsDef, 10);
    send_list(MaxPartsDef + 1, 10);
    send_list(MaxPartsDef + 6, 10);
    wait_idle();
    // Slowest case: a full list against the largest target.
    write_target(11'd1024);
    send_list(MaxPartsDef, 1024);
    wait_idle();
  endtask

  // The receiver holds off long enough for the block to back up its input.
  task automatic test_result_backpressure();
    write_target(11'd6);
    out_gaps_on = 1'b0;
    long_hold_left = 2000;
    for (int n = 0; n < 25; n++) begin
      send_list($urandom_range(2, 4), 6);
    end
    wait_idle();
    out_gaps_on = 1'b1;
  endtask

  // The sender stops until every count is back, then resumes.
  task automatic test_sender_pause();
    write_target(11'd12);
    for (int n = 0; n < 5; n++) send_list($urandom_range(1, 5), 4);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 5; n++) send_list($urandom_range(1, 5), 4);
    wait_idle();
  endtask

  // Phases of random lists, each with its own target and idling pattern.
  task automatic test_random_lists();
    int unsigned r;
    int unsigned goal;
    int unsigned lists;
    int unsigned len;
    while (parts_sent < 1200) begin
      r = $urandom_range(0, 15);
      case (r)
        0: goal = 0;
        1: goal = 1;
        2: goal = $urandom_range(100, 300);
        default: goal = $urandom_range(2, 48);
      endcase
      write_target(TargetW'(goal));
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      lists = (goal >= 100) ? 2 : $urandom_range(4, 12);
      for (int unsigned n = 0; n < lists; n++) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 10);
        send_list(len, goal);
      end
      wait_idle();
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // Receiver: stall for the drawn number of cycles, or for a long hold.
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_left > 0) begin
        out_stall_i <= 1'b1;
        long_hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expected count.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result ways_count=%0d list_overflow=%0b",
                 $time, ways_count_o, list_overflow_o);
        fail_count++;
      end else begin
        oldest_count = pending_counts.pop_front();
        if (ways_count_o !== oldest_count.ways) begin
          $display("%0t: ways_count expected %0d actual %0d",
                   $time, oldest_count.ways, ways_count_o);
          fail_count++;
        end
        if (list_overflow_o !== oldest_count.ovf) begin
          $display("%0t: list_overflow expected %0b actual %0b",
                   $time, oldest_count.ovf, list_overflow_o);
          fail_count++;
        end
      end
      stall_left = out_gaps_on ? $urandom_range(0, 5) : 0;
    end
  end

  // Safety limit well above the slowest correct run.
  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_list_overflow();
    test_result_backpressure();
    test_sender_pause();
    test_random_lists();
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
